// ===== sv/cwrm_pkg.sv =====
// Package for the center window RGB mean block: shared types, constants and
// the 5/6-bit to 8-bit channel expansion functions. No dependencies.
package cwrm_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int MAX_RADIUS_DEF = 7;

  localparam int PIXEL_BITS    = 16;
  localparam int DIM_BITS      = 10;
  localparam int RADIUS_BITS   = 3;
  localparam int MEAN_BITS     = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam int DIV_STEPS     = 8;
  localparam int DIV_STEP_BITS = 3;

  localparam logic [DIM_BITS-1:0]    WIDTH_RST  = 10'd320;
  localparam logic [DIM_BITS-1:0]    HEIGHT_RST = 10'd240;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 3'd3;
  localparam logic                   SWAP_RST   = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2,
    REG_SWAP_RED_BLUE = 2'd3
  } cwrm_reg_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_WAIT
  } cwrm_state_t;

  typedef struct packed {
    logic                     accept;
    logic                     last;
    logic                     div_step;
    logic [DIV_STEP_BITS-1:0] div_bit;
    logic                     load_out;
  } cwrm_cmd_t;

  // floor(v * 255 / 31) = 8v + floor(7v / 31); the second term uses the
  // reciprocal 265 / 2^13, exact for 7v up to 217.
  function automatic logic [MEAN_BITS-1:0] expand5(input logic [4:0] v);
    logic [7:0]  n;
    logic [16:0] p;
    n = 8'(v) * 8'd7;
    p = 17'(n) * 17'd265;
    return {v, 3'b000} + 8'(p >> 13);
  endfunction

  // floor(v * 255 / 63) = 4v + floor(v / 21).
  function automatic logic [MEAN_BITS-1:0] expand6(input logic [5:0] v);
    logic [1:0] corr;
    if (v == 6'd63) begin
      corr = 2'd3;
    end else if (v >= 6'd42) begin
      corr = 2'd2;
    end else if (v >= 6'd21) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    return {v, 2'b00} + 8'(corr);
  endfunction

endpackage

// ===== sv/cwrm_ctrl.sv =====
// Controller of the center window RGB mean block: handshake state machine
// and division step sequencing. Depends on cwrm_pkg.
module cwrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cwrm_pkg::cwrm_cmd_t cmd
);
  import cwrm_pkg::*;

  cwrm_state_t              state_r, state_nxt;
  logic [DIV_STEP_BITS-1:0] step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_ACCUM: begin
        step_nxt = '0;
        if (in_valid && in_last) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_STEP_BITS'(DIV_STEPS - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.div_bit   = DIV_STEP_BITS'(DIV_STEPS - 1) - step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.last   = in_valid && in_last;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/cwrm_datapath.sv =====
// Datapath of the center window RGB mean block: position counters, window
// test, channel sums, restoring dividers and result register. Uses cwrm_pkg.
module cwrm_datapath #(
  parameter int COORD_BITS = cwrm_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = cwrm_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cwrm_pkg::cwrm_cmd_t                 cmd,
  input  logic [cwrm_pkg::PIXEL_BITS-1:0]     pixel,
  input  logic [cwrm_pkg::DIM_BITS-1:0]       frame_width,
  input  logic [cwrm_pkg::DIM_BITS-1:0]       frame_height,
  input  logic [cwrm_pkg::RADIUS_BITS-1:0]    window_radius,
  input  logic                                swap_red_blue,
  output logic [cwrm_pkg::MEAN_BITS-1:0]      red_mean,
  output logic [cwrm_pkg::MEAN_BITS-1:0]      green_mean,
  output logic [cwrm_pkg::MEAN_BITS-1:0]      blue_mean,
  output logic                                status
);
  import cwrm_pkg::*;

  localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
  localparam int MAX_COUNT  = WIN_SIDE * WIN_SIDE;
  localparam int COUNT_BITS = $clog2(MAX_COUNT + 1);
  localparam int SUM_BITS   = $clog2(MAX_COUNT * 255 + 1);
  localparam int CW         = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
  localparam int RMAX_BITS  = $clog2(MAX_RADIUS + 1);
  localparam int RCW        = (RMAX_BITS > RADIUS_BITS) ? RMAX_BITS : RADIUS_BITS;
  localparam int NCH        = 3;

  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [SUM_BITS-1:0]   sum_r [NCH];
  logic [SUM_BITS-1:0]   sum_upd [NCH];
  logic [COUNT_BITS-1:0] count_r, count_upd;
  logic [SUM_BITS-1:0]   rem_r [NCH];
  logic [MEAN_BITS-1:0]  quo_r [NCH];
  logic [COUNT_BITS-1:0] den_r;
  logic [MEAN_BITS-1:0]  mean_r [NCH];
  logic                  status_r;

  logic [RCW-1:0]        rad;
  logic [CW-1:0]         x, y, w, h, cx, cy, r;
  logic                  in_win;
  logic [MEAN_BITS-1:0]  hi8, mid8, lo8;
  logic [MEAN_BITS-1:0]  ch_val [NCH];
  logic [SUM_BITS-1:0]   trial [NCH];

  assign rad = (RCW'(window_radius) > RCW'(MAX_RADIUS)) ? RCW'(MAX_RADIUS)
                                                         : RCW'(window_radius);
  assign x  = CW'(col_r);
  assign y  = CW'(row_r);
  assign w  = CW'(frame_width);
  assign h  = CW'(frame_height);
  assign cx = CW'(frame_width >> 1);
  assign cy = CW'(frame_height >> 1);
  assign r  = CW'(rad);

  assign in_win = (x < w) && (y < h) && (x + r >= cx) && (x <= cx + r) &&
                  (y + r >= cy) && (y <= cy + r);

  assign hi8  = expand5(pixel[15:11]);
  assign mid8 = expand6(pixel[10:5]);
  assign lo8  = expand5(pixel[4:0]);

  assign ch_val[0] = swap_red_blue ? lo8 : hi8;
  assign ch_val[1] = mid8;
  assign ch_val[2] = swap_red_blue ? hi8 : lo8;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_upd[c] = sum_r[c] + (in_win ? SUM_BITS'(ch_val[c]) : '0);
      trial[c]   = SUM_BITS'(den_r) << cmd.div_bit;
    end
    count_upd = count_r + COUNT_BITS'(in_win);
    if (x + CW'(1) >= w) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  // Frame accumulation; the last pixel hands its totals to the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        sum_r[c] <= '0;
      end
    end else if (cmd.accept) begin
      if (cmd.last) begin
        col_r   <= '0;
        row_r   <= '0;
        count_r <= '0;
        for (int c = 0; c < NCH; c++) begin
          sum_r[c] <= '0;
        end
      end else begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        count_r <= count_upd;
        for (int c = 0; c < NCH; c++) begin
          sum_r[c] <= sum_upd[c];
        end
      end
    end
  end

  // Restoring division, one quotient bit per step from the top bit down.
  // The mean is below 256, so eight steps cover the quotient.
  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.last) begin
      den_r <= count_upd;
      for (int c = 0; c < NCH; c++) begin
        rem_r[c] <= sum_upd[c];
        quo_r[c] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int c = 0; c < NCH; c++) begin
        if (rem_r[c] >= trial[c]) begin
          rem_r[c]              <= rem_r[c] - trial[c];
          quo_r[c][cmd.div_bit] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= (den_r == '0);
      for (int c = 0; c < NCH; c++) begin
        mean_r[c] <= (den_r == '0) ? '0 : quo_r[c];
      end
    end
  end

  assign red_mean   = mean_r[0];
  assign green_mean = mean_r[1];
  assign blue_mean  = mean_r[2];
  assign status     = status_r;

endmodule

// ===== sv/center_window_rgb_mean.sv =====
// Top level of the center window RGB mean block: configuration registers and
// the controller and datapath. Depends on cwrm_pkg, cwrm_ctrl, cwrm_datapath.
//
// The block takes RGB565 pixels of a frame in raster order, one transfer per
// clock, and averages the pixels that fall in a square window of the
// configured radius around the frame center, clipped to the frame. Each
// channel is expanded to 8 bits before it is summed, and red and blue can be
// swapped for BGR565 sources. A transfer with in_last_pixel set closes the
// frame: that pixel still counts, and the block then produces one result
// with the truncated per-channel means and status 0, or zeros and status 1
// when no pixel fell in the window. While a frame streams, a pixel is taken
// every cycle, also while an earlier result waits on out_ready. After the
// last pixel, the three restoring dividers work out the quotient one bit per
// step, top bit first, and then load the result register; in_ready stays low
// through both, longer only if the previous result has not been taken.
// Configuration writes are always accepted and should be made only while
// the block is idle; the position counters and sums clear at reset and after
// every last pixel.
module center_window_rgb_mean #(
  parameter int COORD_BITS = cwrm_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = cwrm_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cwrm_pkg::PIXEL_BITS-1:0]      in_pixel,
  input  logic                                 in_last_pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cwrm_pkg::MEAN_BITS-1:0]       out_red_mean,
  output logic [cwrm_pkg::MEAN_BITS-1:0]       out_green_mean,
  output logic [cwrm_pkg::MEAN_BITS-1:0]       out_blue_mean,
  output logic                                 out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cwrm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cwrm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import cwrm_pkg::*;

  logic [DIM_BITS-1:0]    frame_width_r;
  logic [DIM_BITS-1:0]    frame_height_r;
  logic [RADIUS_BITS-1:0] window_radius_r;
  logic                   swap_red_blue_r;
  cwrm_cmd_t              cmd;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RST;
      frame_height_r  <= HEIGHT_RST;
      window_radius_r <= RADIUS_RST;
      swap_red_blue_r <= SWAP_RST;
    end else if (cfg_valid) begin
      case (cwrm_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[DIM_BITS-1:0];
        REG_WINDOW_RADIUS: window_radius_r <= cfg_data[RADIUS_BITS-1:0];
        REG_SWAP_RED_BLUE: swap_red_blue_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The controller owns the handshakes and sequences the division steps.
  cwrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_pixel),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath tracks position, accumulates the window and divides.
  cwrm_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .pixel         (in_pixel),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .window_radius (window_radius_r),
    .swap_red_blue (swap_red_blue_r),
    .red_mean      (out_red_mean),
    .green_mean    (out_green_mean),
    .blue_mean     (out_blue_mean),
    .status        (out_status)
  );

endmodule

// ===== tb/center_window_rgb_mean_tb.sv =====
// Testbench for center_window_rgb_mean: drives RGB565 frames and register
// writes, predicts the window means per frame and checks every result.
// Depends on cwrm_pkg and the center_window_rgb_mean RTL.
`timescale 1ns / 1ps

module center_window_rgb_mean_tb;
  import cwrm_pkg::*;

  // Status codes carried by out_status.
  localparam logic MEAN_OK      = 1'b0;
  localparam logic WINDOW_EMPTY = 1'b1;

  // After a last pixel the block divides and then loads its result. Before a
  // register write, and at the end of the run, we let DRAIN_CYCLES pass.
  localparam int unsigned DRAIN_CYCLES = 16;
  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [MEAN_BITS-1:0] red;
    logic [MEAN_BITS-1:0] green;
    logic [MEAN_BITS-1:0] blue;
    logic                 status;
  } frame_means_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [PIXEL_BITS-1:0]    in_pixel;
  logic                     in_last_pixel;
  logic                     out_valid;
  logic                     out_ready;
  logic [MEAN_BITS-1:0]     out_red_mean;
  logic [MEAN_BITS-1:0]     out_green_mean;
  logic [MEAN_BITS-1:0]     out_blue_mean;
  logic                     out_status;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  center_window_rgb_mean uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_last_pixel  (in_last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_mean   (out_red_mean),
    .out_green_mean (out_green_mean),
    .out_blue_mean  (out_blue_mean),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predicted copy of the register file. Writes land here at the same edge
  // at which the block accepts them.
  logic [DIM_BITS-1:0]    frame_width_reg;
  logic [DIM_BITS-1:0]    frame_height_reg;
  logic [RADIUS_BITS-1:0] radius_reg;
  logic                   swap_reg;

  // Predicted frame state: raster position, per-channel sums and the number
  // of pixels that fell inside the window so far.
  logic [COORD_BITS_DEF-1:0] col_pos;
  logic [COORD_BITS_DEF-1:0] row_pos;
  logic [15:0]               red_acc;
  logic [15:0]               green_acc;
  logic [15:0]               blue_acc;
  logic [7:0]                hit_count;

  // Means predicted for frames that have been closed but whose result has
  // not come out yet, oldest first.
  frame_means_t pending_means[$];

  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned frames_closed;
  // Chance in percent of an idle burst before each input transfer, and of a
  // stall burst on out_ready at each cycle. Tests change these as they go.
  int unsigned gap_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Channel expansion to 8 bits: floor(v * 255 / full) with full 31 or 63.
  function automatic int unsigned widen(input int unsigned v, input int unsigned full);
    return v * 255 / full;
  endfunction

  function automatic void clear_frame_state();
    col_pos   = '0;
    row_pos   = '0;
    red_acc   = '0;
    green_acc = '0;
    blue_acc  = '0;
    hit_count = '0;
  endfunction

  // Advances the predicted state by one accepted pixel. On a last pixel the
  // expected means are queued and the frame state is cleared.
  function automatic void absorb_pixel(input logic [PIXEL_BITS-1:0] pix, input logic is_last);
    int unsigned  x, y, rad, cx, cy, hi, mid, lo;
    frame_means_t m;
    x   = col_pos;
    y   = row_pos;
    rad = radius_reg;
    if (rad > MAX_RADIUS_DEF) begin
      rad = MAX_RADIUS_DEF;
    end
    cx = frame_width_reg / 2;
    cy = frame_height_reg / 2;
    // A pixel counts only inside the frame and inside the square window.
    if (x < frame_width_reg && y < frame_height_reg &&
        x + rad >= cx && x <= cx + rad && y + rad >= cy && y <= cy + rad) begin
      hi  = widen(pix[15:11], 31);
      mid = widen(pix[10:5], 63);
      lo  = widen(pix[4:0], 31);
      if (swap_reg) begin
        red_acc  = red_acc + 16'(lo);
        blue_acc = blue_acc + 16'(hi);
      end else begin
        red_acc  = red_acc + 16'(hi);
        blue_acc = blue_acc + 16'(lo);
      end
      green_acc = green_acc + 16'(mid);
      hit_count = hit_count + 8'd1;
    end
    // A column at or past the last one wraps, which also covers a width
    // lowered in mid frame and a width of zero. The row wraps at the
    // counter width when no last mark ever comes.
    if (x + 1 >= frame_width_reg) begin
      col_pos = '0;
      row_pos = COORD_BITS_DEF'(y + 1);
    end else begin
      col_pos = COORD_BITS_DEF'(x + 1);
    end
    if (is_last) begin
      if (hit_count == 0) begin
        m.red    = '0;
        m.green  = '0;
        m.blue   = '0;
        m.status = WINDOW_EMPTY;
      end else begin
        m.red    = MEAN_BITS'(red_acc / hit_count);
        m.green  = MEAN_BITS'(green_acc / hit_count);
        m.blue   = MEAN_BITS'(blue_acc / hit_count);
        m.status = MEAN_OK;
      end
      pending_means.push_back(m);
      clear_frame_state();
    end
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Sends one pixel. Called and returning at a falling edge; an optional
  // idle burst comes first, then valid stays high until the transfer.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic is_last);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel      <= pix;
    in_last_pixel <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_pixel(pix, is_last);
    pixels_sent++;
    if (is_last) begin
      frames_closed++;
    end
    @(negedge clk);
  endtask

  // Mostly random pixels, with the all-zero and all-one extremes mixed in.
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends n random pixels; when close is set the final one carries the mark.
  task automatic send_run(input int unsigned n, input logic close);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(pick_pixel(), close && (i == n - 1));
    end
  endtask

  // Waits until every expected result has been taken and the block has had
  // time to finish any division still running.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write transfer. Valid is left high; the caller lowers it
  // once its last write is through.
  task automatic cfg_write(input cwrm_reg_t sel, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      REG_FRAME_WIDTH:   frame_width_reg  = value;
      REG_FRAME_HEIGHT:  frame_height_reg = value;
      REG_WINDOW_RADIUS: radius_reg       = value[RADIUS_BITS-1:0];
      REG_SWAP_RED_BLUE: swap_reg         = value[0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // Writes all four registers while the block is idle. The unused upper
  // data bits of the narrow registers carry random junk that must be dropped.
  task automatic set_config(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
                            input logic [RADIUS_BITS-1:0] r, input logic s);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_WINDOW_RADIUS, {7'($urandom), r});
    cfg_write(REG_SWAP_RED_BLUE, {9'($urandom), s});
    cfg_valid <= 1'b0;
  endtask

  // Frame sizes are mostly small so that frames close often; now and then a
  // dimension is zero, the maximum or anything in range.
  function automatic logic [DIM_BITS-1:0] pick_dim(input int unsigned typical_max);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return DIM_BITS'($urandom_range(0, 1023));
      default: return DIM_BITS'($urandom_range(1, typical_max));
    endcase
  endfunction

  // Right after reset the default registers hold a 320 by 240 frame; a few
  // pixels closed early never reach the window, so the result is empty.
  task automatic test_reset_defaults();
    gap_pct   = 30;
    stall_pct = 30;
    send_run(4, 1'b1);
  endtask

  // Short hand-built frames for the extremes of pixel values and registers.
  task automatic test_directed_frames();
    // 3 by 3 frame, radius 0: only the center pixel counts, and it is white.
    set_config(3, 3, 0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      send_pixel((i == 4) ? 16'hFFFF : pick_pixel(), i == 8);
    end
    // Single pixel frame with swapped channels: full red lands in blue.
    set_config(1, 1, 0, 1'b1);
    send_pixel(16'hF800, 1'b1);
    // Largest radius clipped to a 2 by 2 frame: all four pixels count.
    set_config(2, 2, 7, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    // A width of zero advances the row each pixel and never counts.
    set_config(0, 4, 2, 1'b0);
    send_run(2, 1'b1);
    // A height of zero puts every pixel outside the frame.
    set_config(5, 0, 3, 1'b1);
    send_run(2, 1'b1);
    // Largest frame, closed long before the window.
    set_config(1023, 1023, 7, 1'b1);
    send_run(3, 1'b1);
  endtask

  // The width is lowered while the column counter sits beyond the new last
  // column; the next pixel must wrap to the start of the next row.
  task automatic test_column_past_width();
    gap_pct   = 20;
    stall_pct = 20;
    set_config(8, 4, 1, 1'($urandom));
    send_run(6, 1'b0);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 3);
    cfg_valid <= 1'b0;
    send_run(9, 1'b1);
  endtask

  // A one-column frame without a last mark for more than 1024 rows: the row
  // counter wraps and the center row counts a second time.
  task automatic test_runaway_rows();
    gap_pct   = 10;
    stall_pct = 10;
    set_config(1, 5, 0, 1'($urandom));
    send_run(1030, 1'b1);
  endtask

  // Random frames with random registers. Most frames are complete, some are
  // closed early or late, and some start with a run left over from before.
  task automatic test_random_frames(input int unsigned item_goal,
                                    input int unsigned frame_goal,
                                    input bit idle_mix);
    int unsigned first_item, first_frame, area, len;
    first_item  = pixels_sent;
    first_frame = frames_closed;
    while (pixels_sent - first_item < item_goal || frames_closed - first_frame < frame_goal) begin
      if (idle_mix) begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        set_config(pick_dim(8), pick_dim(6), RADIUS_BITS'($urandom_range(0, 7)),
                   1'($urandom));
      end
      area = frame_width_reg * frame_height_reg;
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, area + 4);
        2: begin
          send_run($urandom_range(1, 6), 1'b0);
          len = (area == 0) ? 1 : area;
        end
        default: len = (area == 0) ? 1 : area;
      endcase
      if (area == 0 || area > 200) begin
        len = $urandom_range(1, 30);
      end
      send_run(len, 1'b1);
    end
  endtask

  // Output side: random stall bursts on out_ready, changed at falling edges.
  initial begin : result_ready_driver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest predicted frame.
  always @(posedge clk) begin : result_check
    frame_means_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d status=%0d",
                               out_red_mean, out_green_mean, out_blue_mean, out_status));
      end else begin
        want = pending_means.pop_front();
        if (out_red_mean !== want.red || out_green_mean !== want.green ||
            out_blue_mean !== want.blue || out_status !== want.status) begin
          note_failure($sformatf(
            "means differ: expected r=%0d g=%0d b=%0d status=%0d, got r=%0d g=%0d b=%0d status=%0d",
            want.red, want.green, want.blue, want.status,
            out_red_mean, out_green_mean, out_blue_mean, out_status));
        end
      end
    end
  end

  // Ends the run when no transfer has happened for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pixel      = '0;
    in_last_pixel = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FRAME_WIDTH;
    cfg_data      = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    mismatches    = 0;
    pixels_sent   = 0;
    frames_closed = 0;
    frame_width_reg  = WIDTH_RST;
    frame_height_reg = HEIGHT_RST;
    radius_reg       = RADIUS_RST;
    swap_reg         = SWAP_RST;
    clear_frame_state();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed_frames();
    test_column_past_width();
    test_runaway_rows();
    test_random_frames(550, 40, 1'b1);
    // The closing stretch runs with both sides always ready.
    test_random_frames(150, 8, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
